>>> src/tlbp_pkg.sv
// shared types and constants for the two-level branch predictor
`default_nettype none
package tlbp_pkg;

    localparam int ENTRIES  = 32;
    localparam int IDX_W    = 5;
    localparam int MAX_E    = 5;
    localparam int HIST_W   = 8;
    localparam int ROW_LEN  = 256;
    localparam int ROW_W    = 2 * ROW_LEN;
    localparam int TAG_W    = 30;
    localparam int ADDR_W   = 5;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [2:0] REG_INDEX_BITS    = 3'd0;
    localparam logic [2:0] REG_HISTORY_BITS  = 3'd1;
    localparam logic [2:0] REG_TAG_BITS      = 3'd2;
    localparam logic [2:0] REG_COUNTER_INIT  = 3'd3;
    localparam logic [2:0] REG_HIST_GLOBAL   = 3'd4;
    localparam logic [2:0] REG_TABLE_GLOBAL  = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE    = 3'd6;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] branch_pc;
        logic [31:0] resolved_target;
        logic        resolved_taken;
        logic [31:0] earlier_prediction;
    } in_item_t;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predict_target;
        logic [31:0] branches_seen;
        logic [31:0] mispredicts_seen;
    } out_item_t;

    typedef struct packed {
        logic [2:0] index_bits;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] counter_init;
        logic       history_global;
        logic       table_global;
        logic [1:0] share_mode;
    } cfg_t;

    // decoded request as it waits between front and back
    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
        logic [HIST_W-1:0] share;
        logic [31:0]       pc4;
        logic [31:0]       target;
        logic              taken;
        logic [31:0]       pred;
    } q_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } back_state_t;

endpackage
`default_nettype wire

>>> src/tlbp_queue.sv
// two-entry request queue between front and back
`default_nettype none
module tlbp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tlbp_pkg::q_item_t push_data,
    input  wire logic              pop,
    output tlbp_pkg::q_item_t      head,
    output logic                   full,
    output logic                   empty
);

    tlbp_pkg::q_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> src/tlbp_front.sv
// front end: accepts requests and decodes index, tag and share bits
`default_nettype none
module tlbp_front (
    input  wire tlbp_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tlbp_pkg::in_item_t in_data,
    input  wire logic               q_full,
    output logic                    push,
    output tlbp_pkg::q_item_t       push_data
);

    logic [2:0]                  eff_e;
    logic [tlbp_pkg::IDX_W-1:0]  idx_mask;
    logic [31:0]                 shifted;
    logic [tlbp_pkg::TAG_W-1:0]  tag_mask;
    logic [31:0]                 pc;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign pc       = in_data.branch_pc;

    // index width saturates at the table size
    always_comb
    begin
        eff_e    = (cfg.index_bits > 3'(tlbp_pkg::MAX_E)) ? 3'(tlbp_pkg::MAX_E)
                                                           : cfg.index_bits;
        idx_mask = tlbp_pkg::IDX_W'((6'd1 << eff_e) - 6'd1);
        shifted  = pc >> (eff_e + 3'd2);
        for (int i = 0; i < tlbp_pkg::TAG_W; i++)
        begin
            tag_mask[i] = (5'(i) < cfg.tag_bits);
        end
    end

    // decoded request
    always_comb
    begin
        push_data.opcode = in_data.opcode;
        push_data.idx    = pc[tlbp_pkg::IDX_W+1:2] & idx_mask;
        push_data.tag    = shifted[tlbp_pkg::TAG_W-1:0] & tag_mask;
        case (cfg.share_mode)
            tlbp_pkg::SHARE_NONE: push_data.share = '0;
            tlbp_pkg::SHARE_LOW:  push_data.share = pc[tlbp_pkg::HIST_W+1:2];
            default:              push_data.share = pc[tlbp_pkg::HIST_W+15:16];
        endcase
        push_data.pc4    = pc + 32'd4;
        push_data.target = in_data.resolved_target;
        push_data.taken  = in_data.resolved_taken;
        push_data.pred   = in_data.earlier_prediction;
    end

endmodule
`default_nettype wire

>>> src/tlbp_back.sv
// back end: btb and counter memories, prediction, training and counters
`default_nettype none
module tlbp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tlbp_pkg::cfg_t      cfg,
    input  wire logic                cfg_clear,
    input  wire tlbp_pkg::q_item_t   head,
    input  wire logic                q_empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tlbp_pkg::out_item_t      out_data
);

    localparam int IW = tlbp_pkg::IDX_W;
    localparam int HW = tlbp_pkg::HIST_W;

    tlbp_pkg::back_state_t state_reg, state_next;

    // memories
    logic [tlbp_pkg::TAG_W-1:0] tag_mem    [tlbp_pkg::ENTRIES];
    logic [31:0]                target_mem [tlbp_pkg::ENTRIES];
    logic [HW-1:0]              hist_mem   [tlbp_pkg::ENTRIES];
    logic [tlbp_pkg::ROW_W-1:0] row_mem    [tlbp_pkg::ENTRIES];

    logic [tlbp_pkg::TAG_W-1:0] tag_rd_reg;
    logic [31:0]                target_rd_reg;
    logic [HW-1:0]              hist_rd_reg;
    logic [tlbp_pkg::ROW_W-1:0] row_rd_reg;

    logic [tlbp_pkg::ENTRIES-1:0] valid_reg;
    logic [tlbp_pkg::ENTRIES-1:0] row_valid_reg;
    logic [HW-1:0]                shared_hist_reg;
    logic [31:0]                  branch_reg, mispredict_reg;
    logic                         out_valid_reg;
    tlbp_pkg::out_item_t          out_data_reg;
    tlbp_pkg::q_item_t            item_reg;

    logic [IW-1:0]              head_row, row;
    logic [3:0]                 eff_h;
    logic [HW-1:0]              hmask, hist, col, new_hist;
    logic                       hit, is_upd, row_fresh, mispredict, exec_go;
    logic [tlbp_pkg::ROW_W-1:0] row_data, new_row;
    logic [1:0]                 ctr, new_ctr;
    tlbp_pkg::out_item_t        result;

    assign pop       = (state_reg == tlbp_pkg::ST_IDLE) && !q_empty;
    assign exec_go   = (state_reg == tlbp_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign head_row  = cfg.table_global ? '0 : head.idx;
    assign row       = cfg.table_global ? '0 : item_reg.idx;

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlbp_pkg::ST_IDLE: if (pop)     state_next = tlbp_pkg::ST_EXEC;
            tlbp_pkg::ST_EXEC: if (exec_go) state_next = tlbp_pkg::ST_IDLE;
            default:                        state_next = tlbp_pkg::ST_IDLE;
        endcase
    end

    // lookup, counter step and result
    always_comb
    begin
        eff_h  = (cfg.history_bits == 4'd0) ? 4'd1 :
                 (cfg.history_bits > 4'(HW)) ? 4'(HW) : cfg.history_bits;
        hmask  = HW'((9'd1 << eff_h) - 9'd1);
        is_upd = (item_reg.opcode == tlbp_pkg::OP_UPDATE);
        hit    = valid_reg[item_reg.idx] && (tag_rd_reg == item_reg.tag);
        hist   = cfg.history_global ? shared_hist_reg : (hit ? hist_rd_reg : '0);
        col    = (hist ^ item_reg.share) & hmask;
        // a row not yet written, or dropped on a local-table miss, reads as init
        row_fresh = !row_valid_reg[row] || (is_upd && !cfg.table_global && !hit);
        row_data  = row_fresh ? {tlbp_pkg::ROW_LEN{cfg.counter_init}} : row_rd_reg;
        ctr       = row_data[{col, 1'b0} +: 2];
        if (item_reg.taken)
            new_ctr = (ctr == 2'd3) ? ctr : ctr + 2'd1;
        else
            new_ctr = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        new_row = row_data;
        new_row[{col, 1'b0} +: 2] = new_ctr;
        mispredict = !((item_reg.taken && item_reg.pred == item_reg.target) ||
                       (!item_reg.taken && item_reg.pred == item_reg.pc4));
        if (cfg.history_global)
            new_hist = {shared_hist_reg[HW-2:0], item_reg.taken} & hmask;
        else if (hit)
            new_hist = {hist_rd_reg[HW-2:0], item_reg.taken} & hmask;
        else
            new_hist = {{(HW-1){1'b0}}, item_reg.taken};

        result.predict_taken    = 1'b0;
        result.predict_target   = '0;
        result.branches_seen    = branch_reg;
        result.mispredicts_seen = mispredict_reg;
        if (is_upd)
        begin
            result.branches_seen    = branch_reg + 32'd1;
            result.mispredicts_seen = mispredict_reg + {31'd0, mispredict};
        end
        else
        begin
            result.predict_taken  = hit && ctr[1];
            result.predict_target = (hit && ctr[1]) ? target_rd_reg : item_reg.pc4;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlbp_pkg::ST_IDLE;
            valid_reg       <= '0;
            row_valid_reg   <= '0;
            shared_hist_reg <= '0;
            branch_reg      <= '0;
            mispredict_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (cfg_clear)
        begin
            valid_reg       <= '0;
            row_valid_reg   <= '0;
            shared_hist_reg <= '0;
            branch_reg      <= '0;
            mispredict_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (exec_go)
            begin
                out_valid_reg  <= 1'b1;
                branch_reg     <= result.branches_seen;
                mispredict_reg <= result.mispredicts_seen;
                if (is_upd)
                begin
                    valid_reg[item_reg.idx] <= 1'b1;
                    row_valid_reg[row]      <= 1'b1;
                    if (cfg.history_global)
                        shared_hist_reg <= new_hist;
                end
            end
        end
    end

    // payload, memory reads and writes
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg      <= head;
            tag_rd_reg    <= tag_mem[head.idx];
            target_rd_reg <= target_mem[head.idx];
            hist_rd_reg   <= hist_mem[head.idx];
            row_rd_reg    <= row_mem[head_row];
        end
        if (exec_go)
        begin
            out_data_reg <= result;
            if (is_upd)
            begin
                tag_mem[item_reg.idx]    <= item_reg.tag;
                target_mem[item_reg.idx] <= item_reg.target;
                row_mem[row]             <= new_row;
                if (!cfg.history_global)
                    hist_mem[item_reg.idx] <= new_hist;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/two_level_branch_predictor.sv
// top level: configuration registers, front, queue and back
// Two-level branch predictor with a 32-entry direct-mapped BTB. Each request
// (predict or update) gives exactly one result. The front decodes a request
// into a two-deep queue; the back takes one request at a time: in its idle
// state it pops it and reads the BTB and the 512-bit counter row from memory,
// and in its execute state it computes the result and writes the row and entry
// back. The back takes no new request before it is through with the last; a
// stalled output holds the back in its execute state. Any write to a defined
// configuration register clears all predictor state in that cycle (row and
// entry valid bits, histories, totals), with no clearing pass.
`default_nettype none
module two_level_branch_predictor (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tlbp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tlbp_pkg::in_item_t        in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tlbp_pkg::out_item_t            out_data
);

    tlbp_pkg::cfg_t    cfg_reg, cfg_next;
    logic              wr_en, cfg_clear;
    logic              push, pop, q_full, q_empty;
    tlbp_pkg::q_item_t push_data, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_clear = wr_en;
        unique case (paddr[4:2])
            tlbp_pkg::REG_INDEX_BITS:   cfg_next.index_bits     = pwdata[2:0];
            tlbp_pkg::REG_HISTORY_BITS: cfg_next.history_bits   = pwdata[3:0];
            tlbp_pkg::REG_TAG_BITS:     cfg_next.tag_bits       = pwdata[4:0];
            tlbp_pkg::REG_COUNTER_INIT: cfg_next.counter_init   = pwdata[1:0];
            tlbp_pkg::REG_HIST_GLOBAL:  cfg_next.history_global = pwdata[0];
            tlbp_pkg::REG_TABLE_GLOBAL: cfg_next.table_global   = pwdata[0];
            tlbp_pkg::REG_SHARE_MODE:   cfg_next.share_mode     = pwdata[1:0];
            default:                    cfg_clear               = 1'b0;
        endcase
    end

    // register read mux
    always_comb
    begin
        unique case (paddr[4:2])
            tlbp_pkg::REG_INDEX_BITS:   prdata = {29'd0, cfg_reg.index_bits};
            tlbp_pkg::REG_HISTORY_BITS: prdata = {28'd0, cfg_reg.history_bits};
            tlbp_pkg::REG_TAG_BITS:     prdata = {27'd0, cfg_reg.tag_bits};
            tlbp_pkg::REG_COUNTER_INIT: prdata = {30'd0, cfg_reg.counter_init};
            tlbp_pkg::REG_HIST_GLOBAL:  prdata = {31'd0, cfg_reg.history_global};
            tlbp_pkg::REG_TABLE_GLOBAL: prdata = {31'd0, cfg_reg.table_global};
            tlbp_pkg::REG_SHARE_MODE:   prdata = {30'd0, cfg_reg.share_mode};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_bits     <= 3'd0;
            cfg_reg.history_bits   <= 4'd1;
            cfg_reg.tag_bits       <= 5'd0;
            cfg_reg.counter_init   <= 2'd1;
            cfg_reg.history_global <= 1'b0;
            cfg_reg.table_global   <= 1'b0;
            cfg_reg.share_mode     <= 2'd0;
        end
        else if (wr_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlbp_front u_front (
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tlbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tlbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> src/tlbp_checker.sv
// port-level checks for the branch predictor and their bind
`default_nettype none
module tlbp_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                pready,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire tlbp_pkg::out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // mispredictions never outnumber branches
    a_mis_le_br: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.mispredicts_seen <= out_data.branches_seen)
        else $error("mispredict total above branch total");

    // a stalled request stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled request withdrawn");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind two_level_branch_predictor tlbp_checker u_tlbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

>>> verif/two_level_branch_predictor_checker.sv
// checker: watches both channels, predicts branch results and compares them
`timescale 1ns / 1ps
module two_level_branch_predictor_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [tlbp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire tlbp_pkg::in_item_t  in_data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire tlbp_pkg::out_item_t out_data,
    output int               fail_count,
    output int               pending
);

    // predictor copy of configuration and state
    logic [2:0]  cfg_index;
    logic [3:0]  cfg_hist;
    logic [4:0]  cfg_tag;
    logic [1:0]  cfg_init;
    logic        cfg_hglob;
    logic        cfg_tglob;
    logic [1:0]  cfg_share;

    logic        btb_valid [tlbp_pkg::ENTRIES];
    logic [31:0] btb_tag [tlbp_pkg::ENTRIES];
    logic [31:0] btb_target [tlbp_pkg::ENTRIES];
    logic [7:0]  btb_hist [tlbp_pkg::ENTRIES];
    logic [7:0]  glob_hist;
    logic [1:0]  counters [tlbp_pkg::ENTRIES][tlbp_pkg::ROW_LEN];
    logic [31:0] branch_count;
    logic [31:0] miss_count;

    tlbp_pkg::out_item_t expected_results[$];

    assign pending = expected_results.size();

    function automatic void clear_predictor();
        for (int i = 0; i < tlbp_pkg::ENTRIES; i++)
        begin
            btb_valid[i] = 1'b0;
            btb_tag[i] = '0;
            btb_target[i] = '0;
            btb_hist[i] = '0;
            for (int j = 0; j < tlbp_pkg::ROW_LEN; j++)
                counters[i][j] = cfg_init;
        end
        glob_hist = '0;
        branch_count = '0;
        miss_count = '0;
    endfunction

    function automatic logic [7:0] pick_column(logic [31:0] pc, logic [7:0] hist,
                                               logic [7:0] hmask);
        if (cfg_share == tlbp_pkg::SHARE_NONE)
            return hist & hmask;
        if (cfg_share == tlbp_pkg::SHARE_LOW)
            return (pc[9:2] ^ hist) & hmask;
        return (pc[23:16] ^ hist) & hmask;
    endfunction

    // one request through the predictor
    function automatic tlbp_pkg::out_item_t predict_branch(tlbp_pkg::in_item_t req);
        int          ib;
        int          hb;
        logic [7:0]  hmask;
        logic [4:0]  idx;
        logic [31:0] tag;
        logic        hit;
        int          row;
        logic [31:0] pc4;
        logic [7:0]  hist;
        logic [7:0]  col;
        tlbp_pkg::out_item_t res;
        ib = cfg_index;
        while (ib > tlbp_pkg::MAX_E)
            ib--;
        hb = cfg_hist;
        if (hb < 1)
            hb = 1;
        if (hb > tlbp_pkg::HIST_W)
            hb = tlbp_pkg::HIST_W;
        hmask = 8'((1 << hb) - 1);
        idx = 5'((req.branch_pc >> 2) & ((32'd1 << ib) - 1));
        tag = (req.branch_pc >> (ib + 2)) & ((32'd1 << cfg_tag) - 1);
        hit = btb_valid[idx] && btb_tag[idx] == tag;
        row = cfg_tglob ? 0 : idx;
        pc4 = req.branch_pc + 32'd4;
        res = '0;
        if (req.opcode == tlbp_pkg::OP_PREDICT)
        begin
            res.predict_target = pc4;
            if (hit)
            begin
                hist = cfg_hglob ? glob_hist : btb_hist[idx];
                col = pick_column(req.branch_pc, hist, hmask);
                if (counters[row][col] >= 2'd2)
                begin
                    res.predict_taken = 1'b1;
                    res.predict_target = btb_target[idx];
                end
            end
        end
        else
        begin
            hist = cfg_hglob ? glob_hist : (hit ? btb_hist[idx] : 8'd0);
            col = pick_column(req.branch_pc, hist, hmask);
            if (!cfg_tglob && !hit)
                for (int j = 0; j < tlbp_pkg::ROW_LEN; j++)
                    counters[row][j] = cfg_init;
            if (req.resolved_taken && counters[row][col] != 2'd3)
                counters[row][col]++;
            else if (!req.resolved_taken && counters[row][col] != 2'd0)
                counters[row][col]--;
            if (!((req.resolved_taken && req.earlier_prediction == req.resolved_target)
                  || (!req.resolved_taken && req.earlier_prediction == pc4)))
                miss_count++;
            btb_target[idx] = req.resolved_target;
            if (cfg_hglob)
                glob_hist = ((glob_hist << 1) | req.resolved_taken) & hmask;
            else if (hit)
                btb_hist[idx] = ((btb_hist[idx] << 1) | req.resolved_taken) & hmask;
            else
                btb_hist[idx] = {7'd0, req.resolved_taken};
            btb_tag[idx] = tag;
            btb_valid[idx] = 1'b1;
            branch_count++;
        end
        res.branches_seen = branch_count;
        res.mispredicts_seen = miss_count;
        return res;
    endfunction

    // register writes, accepted requests and results
    always @(posedge clk or negedge rst_n)
    begin
        tlbp_pkg::out_item_t want;
        if (!rst_n)
        begin
            cfg_index = 3'd0;
            cfg_hist = 4'd1;
            cfg_tag = 5'd0;
            cfg_init = 2'd1;
            cfg_hglob = 1'b0;
            cfg_tglob = 1'b0;
            cfg_share = 2'd0;
            clear_predictor();
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    tlbp_pkg::REG_INDEX_BITS:   cfg_index = pwdata[2:0];
                    tlbp_pkg::REG_HISTORY_BITS: cfg_hist = pwdata[3:0];
                    tlbp_pkg::REG_TAG_BITS:     cfg_tag = pwdata[4:0];
                    tlbp_pkg::REG_COUNTER_INIT: cfg_init = pwdata[1:0];
                    tlbp_pkg::REG_HIST_GLOBAL:  cfg_hglob = pwdata[0];
                    tlbp_pkg::REG_TABLE_GLOBAL: cfg_tglob = pwdata[0];
                    tlbp_pkg::REG_SHARE_MODE:   cfg_share = pwdata[1:0];
                    default:                    ;
                endcase
                // only a defined register restarts the predictor
                if (paddr[4:2] <= tlbp_pkg::REG_SHARE_MODE)
                    clear_predictor();
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_branch(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.predict_taken !== out_data.predict_taken)
                    begin
                        $display("%0t: predict_taken expected %0d actual %0d", $time,
                                 want.predict_taken, out_data.predict_taken);
                        fail_count++;
                    end
                    if (want.predict_target !== out_data.predict_target)
                    begin
                        $display("%0t: predict_target expected %h actual %h", $time,
                                 want.predict_target, out_data.predict_target);
                        fail_count++;
                    end
                    if (want.branches_seen !== out_data.branches_seen)
                    begin
                        $display("%0t: branches_seen expected %0d actual %0d", $time,
                                 want.branches_seen, out_data.branches_seen);
                        fail_count++;
                    end
                    if (want.mispredicts_seen !== out_data.mispredicts_seen)
                    begin
                        $display("%0t: mispredicts_seen expected %0d actual %0d", $time,
                                 want.mispredicts_seen, out_data.mispredicts_seen);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> verif/two_level_branch_predictor_tb.sv
// testbench top: clock, reset, register writes, request stimulus and verdict
`timescale 1ns / 1ps
module two_level_branch_predictor_tb;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tlbp_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    tlbp_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_stall;
    tlbp_pkg::out_item_t out_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          out_wait;

    // pcs drawn from a small pool so that entries get hit again
    logic [31:0] pc_pool [16];

    two_level_branch_predictor dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    two_level_branch_predictor_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result-side stall drawn at random for every result
    always @(posedge clk)
    begin
        int wait_cycles;
        wait_cycles = $urandom_range(0, 3);
        if (out_valid && !out_stall)
        begin
            out_wait <= wait_cycles;
            out_stall <= (wait_cycles != 0);
        end
        else if (out_valid && out_stall)
        begin
            out_wait <= out_wait - 1;
            out_stall <= (out_wait > 1);
        end
    end

    task automatic write_reg(input logic [2:0] which, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] ib, input logic [3:0] hb,
                              input logic [4:0] tb, input logic [1:0] ci,
                              input logic hg, input logic tg, input logic [1:0] sm);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(tlbp_pkg::REG_INDEX_BITS, {$urandom} & 32'hfffffff8 | ib);
        write_reg(tlbp_pkg::REG_HISTORY_BITS, hb);
        write_reg(tlbp_pkg::REG_TAG_BITS, tb);
        write_reg(tlbp_pkg::REG_COUNTER_INIT, ci);
        write_reg(tlbp_pkg::REG_HIST_GLOBAL, hg);
        write_reg(tlbp_pkg::REG_TABLE_GLOBAL, tg);
        write_reg(tlbp_pkg::REG_SHARE_MODE, sm);
    endtask

    // valid stays up into the next request when there is no gap
    task automatic send_request(input tlbp_pkg::in_item_t req);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random predict or update request: earlier prediction mostly consistent with outcome
    function automatic tlbp_pkg::in_item_t make_branch(input logic [31:0] pc);
        tlbp_pkg::in_item_t req;
        req.opcode = $urandom_range(0, 1) ? tlbp_pkg::OP_UPDATE : tlbp_pkg::OP_PREDICT;
        req.branch_pc = pc;
        req.resolved_target = ($urandom_range(0, 3) == 0) ? $urandom : pc + 32'h40;
        req.resolved_taken = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0: req.earlier_prediction = $urandom;
            1: req.earlier_prediction = pc + 32'd4;
            default: req.earlier_prediction = req.resolved_taken ?
                         req.resolved_target : pc + 32'd4;
        endcase
        return req;
    endfunction

    task automatic random_phase(input int count);
        tlbp_pkg::in_item_t req;
        for (int i = 0; i < 16; i++)
            pc_pool[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                req = make_branch($urandom);
            else
                req = make_branch(pc_pool[$urandom_range(0, 15)]);
            send_request(req);
        end
    endtask

    initial
    begin
        tlbp_pkg::in_item_t req;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        out_wait = 0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset configuration, extremes of the fields, both operations
        req = '0;
        send_request(req);
        req = '1;
        req.opcode = tlbp_pkg::OP_UPDATE;
        send_request(req);
        req.opcode = tlbp_pkg::OP_PREDICT;
        send_request(req);
        req = '0;
        req.opcode = tlbp_pkg::OP_UPDATE;
        req.branch_pc = 32'h0000_1000;
        req.resolved_taken = 1'b1;
        req.resolved_target = 32'h0000_2000;
        req.earlier_prediction = 32'h0000_2000;
        send_request(req);
        send_request(req);
        req.opcode = tlbp_pkg::OP_PREDICT;
        send_request(req);
        req.opcode = tlbp_pkg::OP_UPDATE;
        req.resolved_taken = 1'b0;
        req.earlier_prediction = 32'h0000_1004;
        send_request(req);
        send_request(req);
        req.opcode = tlbp_pkg::OP_PREDICT;
        send_request(req);

        // oversized index, zero history, share selector three
        set_config(3'd7, 4'd0, 5'd30, 2'd3, 1'b0, 1'b0, 2'd3);
        req = '0;
        req.opcode = tlbp_pkg::OP_UPDATE;
        req.branch_pc = 32'hfffffffc;
        req.resolved_taken = 1'b1;
        req.resolved_target = 32'h1234_5678;
        req.earlier_prediction = 32'h1234_5678;
        send_request(req);
        req.opcode = tlbp_pkg::OP_PREDICT;
        send_request(req);
        req.branch_pc = 32'h7ffffffc;
        send_request(req);
        random_phase(60);

        set_config(3'd5, 4'd15, 5'd31, 2'd0, 1'b1, 1'b1, 2'd1);
        random_phase(100);
        set_config(3'd0, 4'd8, 5'd0, 2'd2, 1'b1, 1'b0, 2'd2);
        random_phase(80);
        set_config(3'd3, 4'd3, 5'd4, 2'd1, 1'b0, 1'b1, 2'd0);
        random_phase(100);
        set_config(3'd5, 4'd8, 5'd30, 2'd3, 1'b0, 1'b0, 2'd2);
        random_phase(100);
        set_config(3'd2, 4'd1, 5'd2, 2'd0, 1'b1, 1'b1, 2'd3);
        random_phase(100);
        set_config(3'd4, 4'd5, 5'd10, 2'd2, 1'b0, 1'b0, 2'd1);
        random_phase(100);

        // drain
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/tlbp_pkg.sv
src/tlbp_queue.sv
src/tlbp_front.sv
src/tlbp_back.sv
src/two_level_branch_predictor.sv
src/tlbp_checker.sv
verif/two_level_branch_predictor_checker.sv
verif/two_level_branch_predictor_tb.sv
